[hdl/hrbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbp_pkg
// Shared constants, codes and character tables for the HTTP request byte
// parser.
// ----------------------------------------------------------------------------
package hrbp_pkg;

  // Width of the internal length accumulator.
  localparam int LENGTH_BITS = 32;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Parse phases.
  localparam logic [3:0] PH_METHOD     = 4'd0;
  localparam logic [3:0] PH_PATH       = 4'd1;
  localparam logic [3:0] PH_QUERY      = 4'd2;
  localparam logic [3:0] PH_VERSION    = 4'd3;
  localparam logic [3:0] PH_LF         = 4'd4;
  localparam logic [3:0] PH_LINE_START = 4'd5;
  localparam logic [3:0] PH_LINE       = 4'd6;
  localparam logic [3:0] PH_BLANK_LF   = 4'd7;
  localparam logic [3:0] PH_BODY       = 4'd8;

  // Header value sub-phases.
  localparam logic [1:0] VP_NAME   = 2'd0;
  localparam logic [1:0] VP_SPACES = 2'd1;
  localparam logic [1:0] VP_DIGITS = 2'd2;
  localparam logic [1:0] VP_REST   = 2'd3;

  // Field tags.
  localparam logic [2:0] TAG_DELIM   = 3'd0;
  localparam logic [2:0] TAG_METHOD  = 3'd1;
  localparam logic [2:0] TAG_PATH    = 3'd2;
  localparam logic [2:0] TAG_QUERY   = 3'd3;
  localparam logic [2:0] TAG_VERSION = 3'd4;
  localparam logic [2:0] TAG_HNAME   = 3'd5;
  localparam logic [2:0] TAG_HVALUE  = 3'd6;
  localparam logic [2:0] TAG_BODY    = 3'd7;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERSION  = 2'd1;
  localparam logic [1:0] ERR_NO_LF    = 2'd2;
  localparam logic [1:0] ERR_NO_COLON = 2'd3;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // Lengths of the matched strings.
  localparam logic [3:0] VER_LEN  = 4'd8;
  localparam logic [3:0] NAME_LEN = 4'd14;
  localparam logic [3:0] IDX_MAX  = 4'd15;

  localparam logic [63:0]  VER_A   = "HTTP/1.0";
  localparam logic [63:0]  VER_B   = "HTTP/1.1";
  localparam logic [111:0] CL_NAME = "content-length";

  // Character of "HTTP/1.0" at a position.
  function automatic logic [7:0] ver_a_char(input logic [2:0] idx);
    ver_a_char = VER_A[63 - 8 * idx -: 8];
  endfunction

  // Character of "HTTP/1.1" at a position.
  function automatic logic [7:0] ver_b_char(input logic [2:0] idx);
    ver_b_char = VER_B[63 - 8 * idx -: 8];
  endfunction

  // Character of the lower-case header name at a position below 14.
  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    cl_char = CL_NAME[111 - 8 * idx -: 8];
  endfunction

  // ASCII lower-case fold.
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      lower_ascii = c + 8'd32;
    end else begin
      lower_ascii = c;
    end
  endfunction

endpackage

[hdl/http_request_byte_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_byte_parser
// Tags each byte of an HTTP request stream, checks the version, decodes the
// Content-Length header and flags framing errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_ready with data_byte, one request byte per
//   item. Output channel: out_valid / out_ready with byte_out, field_tag,
//   message_complete, error_code and content_length, one result per item.
//   An item is taken into an input register; once the output register is free,
//   the parse logic updates the parser state and loads the output register.
//   Throughput is one item per cycle while the receiver keeps up: both
//   registers advance together, and the input register refills in the same
//   cycle that it drains.
//   When the receiver stalls, the output register holds its result, the
//   input register holds one more item, and in_ready falls until the output
//   drains; no item is lost or repeated.
//   Reset (rst, synchronous) empties both registers and returns the parser
//   to the start of a request with no error and zero length. An error stays
//   in error_code until reset; a request with no body returns the parser to
//   its start state on the final blank-line LF.
// ----------------------------------------------------------------------------
module http_request_byte_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   byte_out,
  output logic [2:0]                   field_tag,
  output logic                         message_complete,
  output logic [1:0]                   error_code,
  output logic [31:0]                  content_length
);
  import hrbp_pkg::*;

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;

  // Parser state.
  logic [3:0]             parse_phase;
  logic                   skip_next;
  logic [3:0]             version_index;
  logic [1:0]             version_match;
  logic [3:0]             name_index;
  logic                   name_match;
  logic [1:0]             value_phase;
  logic [LENGTH_BITS-1:0] length_value;
  logic [1:0]             sticky_error;

  logic [3:0]             parse_phase_next;
  logic                   skip_next_next;
  logic [3:0]             version_index_next;
  logic [1:0]             version_match_next;
  logic [3:0]             name_index_next;
  logic                   name_match_next;
  logic [1:0]             value_phase_next;
  logic [LENGTH_BITS-1:0] length_value_next;
  logic [1:0]             sticky_error_next;

  logic [2:0]             tag;
  logic                   done;
  logic                   restart;

  // Digit accumulation: length * 10 + digit, with saturation.
  logic [LENGTH_BITS+3:0] len_times_ten;
  logic [LENGTH_BITS+3:0] len_sum;
  logic [LENGTH_BITS-1:0] len_acc;
  logic                   is_digit;
  logic                   nm_colon;

  logic advance;

  // The input register moves to the output whenever the output is free.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  assign len_times_ten = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1);
  assign len_sum       = len_times_ten + (LENGTH_BITS + 4)'(in_byte - CH_ZERO);
  assign len_acc       = (len_sum > {4'd0, LEN_MAX}) ? LEN_MAX : len_sum[LENGTH_BITS-1:0];
  assign is_digit      = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign nm_colon      = name_match && (name_index == NAME_LEN);

  // Per-byte parse step.
  always_comb begin
    parse_phase_next   = parse_phase;
    skip_next_next     = skip_next;
    version_index_next = version_index;
    version_match_next = version_match;
    name_index_next    = name_index;
    name_match_next    = name_match;
    value_phase_next   = value_phase;
    length_value_next  = length_value;
    sticky_error_next  = sticky_error;
    tag                = TAG_DELIM;
    done               = 1'b0;
    restart            = 1'b0;

    if (sticky_error != ERR_NONE) begin
      // Every byte is ignored after an error.
    end else if (skip_next) begin
      skip_next_next = 1'b0;
    end else begin
      case (parse_phase)
        PH_METHOD: begin
          if (in_byte == CH_SPACE) begin
            skip_next_next   = 1'b1;
            parse_phase_next = PH_PATH;
          end else begin
            tag = TAG_METHOD;
          end
        end
        PH_PATH: begin
          if (in_byte == CH_QMARK) begin
            parse_phase_next = PH_QUERY;
          end else if (in_byte == CH_SPACE) begin
            parse_phase_next = PH_VERSION;
          end else begin
            tag = TAG_PATH;
          end
        end
        PH_QUERY: begin
          if (in_byte == CH_SPACE) begin
            parse_phase_next = PH_VERSION;
          end else begin
            tag = TAG_QUERY;
          end
        end
        PH_VERSION: begin
          if (in_byte == CH_CR) begin
            if (version_index == VER_LEN && version_match != 2'b00) begin
              parse_phase_next = PH_LF;
            end else begin
              sticky_error_next = ERR_VERSION;
            end
          end else begin
            // Track both acceptable versions in parallel.
            if (version_index < VER_LEN) begin
              version_match_next = version_match
                & {in_byte == ver_b_char(version_index[2:0]),
                   in_byte == ver_a_char(version_index[2:0])};
            end else begin
              version_match_next = 2'b00;
            end
            if (version_index < IDX_MAX) begin
              version_index_next = version_index + 4'd1;
            end
            tag = TAG_VERSION;
          end
        end
        PH_LF: begin
          if (in_byte != CH_LF) begin
            sticky_error_next = ERR_NO_LF;
          end else begin
            name_index_next  = 4'd0;
            name_match_next  = 1'b1;
            value_phase_next = VP_NAME;
            parse_phase_next = PH_LINE_START;
          end
        end
        PH_LINE_START, PH_LINE: begin
          if (parse_phase == PH_LINE_START && in_byte == CH_CR) begin
            parse_phase_next = PH_BLANK_LF;
          end else if (in_byte == CH_CR) begin
            if (value_phase == VP_NAME) begin
              sticky_error_next = ERR_NO_COLON;
            end else begin
              parse_phase_next = PH_LF;
            end
          end else begin
            parse_phase_next = PH_LINE;
            if (value_phase == VP_NAME) begin
              // Header name: match against the length header name.
              if (in_byte == CH_COLON) begin
                name_match_next  = nm_colon;
                if (nm_colon) begin
                  length_value_next = '0;
                end
                value_phase_next = VP_SPACES;
              end else begin
                if (name_index >= NAME_LEN ||
                    lower_ascii(in_byte) != cl_char(name_index)) begin
                  name_match_next = 1'b0;
                end
                if (name_index < IDX_MAX) begin
                  name_index_next = name_index + 4'd1;
                end
                tag = TAG_HNAME;
              end
            end else if (value_phase == VP_SPACES && in_byte == CH_SPACE) begin
              // Spaces after the colon are delimiters.
            end else begin
              // Header value; leading digits build the length.
              if (value_phase == VP_SPACES) begin
                value_phase_next = VP_DIGITS;
              end
              if ((value_phase == VP_SPACES || value_phase == VP_DIGITS) && name_match) begin
                if (is_digit) begin
                  length_value_next = len_acc;
                end else begin
                  value_phase_next = VP_REST;
                end
              end
              tag = TAG_HVALUE;
            end
          end
        end
        PH_BLANK_LF: begin
          if (in_byte != CH_LF) begin
            sticky_error_next = ERR_NO_LF;
          end else if (length_value == '0) begin
            done    = 1'b1;
            restart = 1'b1;
          end else begin
            parse_phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          tag  = TAG_BODY;
          done = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_out         <= in_byte;
      field_tag        <= tag;
      message_complete <= done;
      error_code       <= sticky_error_next;
      content_length   <= 32'(length_value_next);
    end
  end

  // Parser state update, one byte per advance.
  always_ff @(posedge clk) begin
    if (rst || (advance && restart)) begin
      parse_phase   <= PH_METHOD;
      skip_next     <= 1'b0;
      version_index <= 4'd0;
      version_match <= 2'b11;
      name_index    <= 4'd0;
      name_match    <= 1'b1;
      value_phase   <= VP_NAME;
      length_value  <= '0;
      sticky_error  <= ERR_NONE;
    end else if (advance) begin
      parse_phase   <= parse_phase_next;
      skip_next     <= skip_next_next;
      version_index <= version_index_next;
      version_match <= version_match_next;
      name_index    <= name_index_next;
      name_match    <= name_match_next;
      value_phase   <= value_phase_next;
      length_value  <= length_value_next;
      sticky_error  <= sticky_error_next;
    end
  end

endmodule

[bench/tb_http_request_byte_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_byte_parser
// Self-checking bench for the HTTP request byte parser. A byte-level
// predictor tags every accepted item. The result of each item is compared
// with the oldest prediction. The stimulus is a directed request line,
// random well-formed requests under several idle and stall mixes with one
// long receiver hold-off, and a final random terminal case: either a body
// or one of the sticky errors.
// ----------------------------------------------------------------------------
module tb_http_request_byte_parser;
  import hrbp_pkg::*;

  localparam int PHASE_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  tag;
    logic        done;
    logic [1:0]  err;
    logic [31:0] len;
  } tagged_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  byte_out;
  logic [2:0]  field_tag;
  logic        message_complete;
  logic [1:0]  error_code;
  logic [31:0] content_length;

  // Predicted results, oldest first.
  tagged_byte_t pending_tags[$];
  int           fail_count = 0;
  int           bytes_sent = 0;

  // Idle mix of the sender and the receiver, in percent.
  int gap_pct   = 0;
  int stall_pct = 0;

  // Long receiver hold-off.
  logic pressure_on = 1'b0;
  int   hold_count  = 0;

  // Predictor state.
  logic [3:0]  phase_q;
  logic        skip_q;
  logic [3:0]  vidx_q;
  logic [1:0]  vmatch_q;
  logic [3:0]  nidx_q;
  logic        nmatch_q;
  logic [1:0]  vphase_q;
  logic [31:0] len_q;
  logic [1:0]  err_q;

  string ver10   = "HTTP/1.0";
  string ver11   = "HTTP/1.1";
  string cl_text = "content-length";

  http_request_byte_parser u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .byte_out         (byte_out),
    .field_tag        (field_tag),
    .message_complete (message_complete),
    .error_code       (error_code),
    .content_length   (content_length)
  );

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("** http_request_byte_parser: FAILED **");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off while pressure is on.
  always @(posedge clk) begin
    if (pressure_on && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!pressure_on) begin
        hold_count <= 0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    tagged_byte_t want;
    tagged_byte_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = '{byte_out, field_tag, message_complete, error_code, content_length};
      if (pending_tags.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result byte=%h tag=%0d done=%0d err=%0d len=%0d",
                 $time, got.data, got.tag, got.done, got.err, got.len);
      end else begin
        want = pending_tags.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: mismatch expected byte=%h tag=%0d done=%0d err=%0d len=%0d",
                   $time, want.data, want.tag, want.done, want.err, want.len);
          $display("%0t:          actual   byte=%h tag=%0d done=%0d err=%0d len=%0d",
                   $time, got.data, got.tag, got.done, got.err, got.len);
        end
      end
    end
  end

  // Return the predictor to the start of a request.
  task automatic clear_parser();
    phase_q  = PH_METHOD;
    skip_q   = 1'b0;
    vidx_q   = '0;
    vmatch_q = 2'b11;
    nidx_q   = '0;
    nmatch_q = 1'b1;
    vphase_q = VP_NAME;
    len_q    = '0;
    err_q    = ERR_NONE;
  endtask

  // Tag one accepted byte and queue its expected result.
  task automatic tag_byte(input logic [7:0] c);
    logic [2:0]  tag;
    logic        done;
    logic        restart;
    logic [7:0]  folded;
    logic [63:0] acc;
    tag     = TAG_DELIM;
    done    = 1'b0;
    restart = 1'b0;
    if (err_q != ERR_NONE) begin
      // Every byte is ignored after an error.
    end else if (skip_q) begin
      skip_q = 1'b0;
    end else begin
      case (phase_q)
        PH_PATH: begin
          if (c == CH_QMARK) phase_q = PH_QUERY;
          else if (c == CH_SPACE) phase_q = PH_VERSION;
          else tag = TAG_PATH;
        end
        PH_QUERY: begin
          if (c == CH_SPACE) phase_q = PH_VERSION;
          else tag = TAG_QUERY;
        end
        PH_VERSION: begin
          if (c == CH_CR) begin
            if (vidx_q == 4'd8 && vmatch_q != 2'b00) phase_q = PH_LF;
            else err_q = ERR_VERSION;
          end else begin
            if (vidx_q < 4'd8) begin
              if (c != ver10[vidx_q]) vmatch_q &= 2'b10;
              if (c != ver11[vidx_q]) vmatch_q &= 2'b01;
            end else begin
              vmatch_q = 2'b00;
            end
            if (vidx_q < 4'd15) vidx_q++;
            tag = TAG_VERSION;
          end
        end
        PH_LF: begin
          if (c != CH_LF) begin
            err_q = ERR_NO_LF;
          end else begin
            nidx_q   = '0;
            nmatch_q = 1'b1;
            vphase_q = VP_NAME;
            phase_q  = PH_LINE_START;
          end
        end
        PH_LINE_START, PH_LINE: begin
          if (phase_q == PH_LINE_START && c == CH_CR) begin
            phase_q = PH_BLANK_LF;
          end else if (c == CH_CR) begin
            if (vphase_q == VP_NAME) err_q = ERR_NO_COLON;
            else phase_q = PH_LF;
          end else begin
            phase_q = PH_LINE;
            if (vphase_q == VP_NAME) begin
              // Header name: case-folded match against the length header.
              if (c == CH_COLON) begin
                nmatch_q = nmatch_q && (nidx_q == 4'd14);
                if (nmatch_q) len_q = '0;
                vphase_q = VP_SPACES;
              end else begin
                folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                if (nidx_q >= 4'd14 || folded != cl_text[nidx_q]) nmatch_q = 1'b0;
                if (nidx_q < 4'd15) nidx_q++;
                tag = TAG_HNAME;
              end
            end else begin
              // Header value: skip leading spaces, then decode leading digits.
              tag = TAG_HVALUE;
              if (vphase_q == VP_SPACES) begin
                if (c == CH_SPACE) tag = TAG_DELIM;
                else vphase_q = VP_DIGITS;
              end
              if (tag == TAG_HVALUE && vphase_q == VP_DIGITS && nmatch_q) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                  acc   = {32'd0, len_q} * 64'd10 + {56'd0, c - CH_ZERO};
                  len_q = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                end else begin
                  vphase_q = VP_REST;
                end
              end
            end
          end
        end
        PH_BLANK_LF: begin
          if (c != CH_LF) begin
            err_q = ERR_NO_LF;
          end else if (len_q == '0) begin
            done    = 1'b1;
            restart = 1'b1;
          end else begin
            phase_q = PH_BODY;
          end
        end
        PH_BODY: begin
          tag  = TAG_BODY;
          done = 1'b1;
        end
        default: begin
          if (c == CH_SPACE) begin
            skip_q  = 1'b1;
            phase_q = PH_PATH;
          end else begin
            tag = TAG_METHOD;
          end
        end
      endcase
    end
    pending_tags.push_back('{c, tag, done, err_q, len_q});
    if (restart) clear_parser();
  endtask

  // Offer one item after a random gap and wait until it is accepted.
  // Valid stays high on return so that a following item can go back to back.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    tag_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    while (r == a || r == b) r = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Method, dropped byte, path, optional query and the given version text.
  task automatic send_request_line(input string version);
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range("A", "Z")));
      else send_byte(rand_byte_except(CH_SPACE, CH_SPACE));
    end
    send_byte(CH_SPACE);
    // The dropped byte is usually the leading slash but may be anything.
    if ($urandom_range(0, 3) != 0) send_byte("/");
    else send_byte(8'($urandom_range(0, 255)));
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) send_byte(rand_byte_except(CH_QMARK, CH_SPACE));
    if ($urandom_range(0, 1)) begin
      send_byte(CH_QMARK);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_byte(rand_byte_except(CH_SPACE, CH_SPACE));
    end
    send_byte(CH_SPACE);
    send_text(version);
  endtask

  // A length header with random letter case and a value of random shape.
  task automatic send_length_header();
    logic [7:0] c;
    int         n;
    for (int i = 0; i < cl_text.len(); i++) begin
      c = cl_text[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      send_byte(c);
    end
    // Sometimes a near miss: one character too many.
    case ($urandom_range(0, 9))
      0: send_byte("s");
      1: send_byte("_");
      default: ;
    endcase
    send_byte(CH_COLON);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_byte(CH_SPACE);
    case ($urandom_range(0, 5))
      0, 1: send_text($sformatf("%0d", $urandom_range(0, 99999)));
      2: begin
        // Long enough that it may saturate.
        n = $urandom_range(10, 22);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      3: send_byte(CH_ZERO);
      4: begin
        send_byte($urandom_range(0, 1) ? "+" : "-");
        send_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      default: ;
    endcase
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_byte(rand_byte_except(CH_CR, CH_CR));
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Any other header line, with a random name and value.
  task automatic send_other_header();
    int n;
    n = $urandom_range(0, 16);
    for (int i = 0; i < n; i++) send_byte(rand_byte_except(CH_COLON, CH_CR));
    send_byte(CH_COLON);
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) send_byte(rand_byte_except(CH_CR, CH_CR));
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // One complete request with no body; the length is forced back to zero.
  task automatic send_random_request();
    int n;
    send_request_line($urandom_range(0, 1) ? ver11 : ver10);
    send_byte(CH_CR);
    send_byte(CH_LF);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) send_length_header();
      else send_other_header();
    end
    if (len_q != '0) send_text("Content-Length: 0\r\n");
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Directed request line: extreme method bytes, a dropped '?', a query.
  task automatic test_request_line();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_SPACE);
    send_byte(CH_QMARK);
    send_byte(CH_QMARK);
    send_byte("q");
    send_byte(CH_SPACE);
    send_text(ver10);
    send_text("\r\n\r\n");
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    pressure_on <= 1'b1;
    do send_random_request(); while (hold_count < HOLD_CYCLES);
    pressure_on <= 1'b0;
  endtask

  // Random requests under each idle mix.
  task automatic test_random_requests();
    int gaps[4]   = '{0, 49, 0, 17};
    int stalls[4] = '{0, 0, 49, 17};
    int mark;
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      mark      = bytes_sent;
      while (bytes_sent - mark < PHASE_ITEMS) send_random_request();
    end
  endtask

  // End in one terminal state: a body, or one of the sticky errors.
  task automatic test_terminal_state();
    int n;
    gap_pct   = 17;
    stall_pct = 17;
    case ($urandom_range(0, 3))
      0: begin
        send_request_line(ver11);
        send_text($sformatf("\r\nContent-Length: %0d\r\n\r\n", $urandom_range(1, 999999)));
      end
      1: begin
        // Bad version.
        case ($urandom_range(0, 3))
          0: send_request_line("HTTP/1.2");
          1: send_request_line("HTTP/1.");
          2: send_request_line("HTTP/1.10");
          default: send_request_line("http/1.1");
        endcase
        send_byte(CH_CR);
      end
      2: begin
        // CR without LF, on the request line, a header line or the blank line.
        send_request_line(ver10);
        n = $urandom_range(0, 2);
        if (n != 0) begin
          send_text("\r\n");
          if (n == 2) send_text("Host: x\r");
          else send_byte(CH_CR);
        end else begin
          send_byte(CH_CR);
        end
        send_byte(rand_byte_except(CH_LF, CH_LF));
      end
      default: begin
        // Header line with no colon.
        send_request_line(ver11);
        send_text("\r\n");
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_byte(rand_byte_except(CH_COLON, CH_CR));
        send_byte(CH_CR);
      end
    endcase
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_request_line();
    test_backpressure();
    test_random_requests();
    test_terminal_state();

    // Drain, then watch for stray results.
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_tags.size() == 0) begin
      $display("** http_request_byte_parser: PASSED **");
    end else begin
      $display("** http_request_byte_parser: FAILED **");
    end
    $finish;
  end

endmodule
